>>> rtl/core/assert_macros.svh
// Assertion macros shared by the card ID table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on the rising edge of i_clk, off while reset is asserted.
`define CIDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, during reset too.
`define CIDT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/cidt_pkg.sv
// Package for the card ID table: sizes, operation codes and the sequencer states.
package cidt_pkg;

    localparam int CAPACITY = 128;
    localparam int ID_W     = 40;
    localparam int OP_W     = 2;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_WAIT   = 2'd2,
        ST_FINISH = 2'd3
    } t_state;

endpackage

>>> rtl/core/card_id_table_unit.sv
// Card ID table: ID store, fill count, admin ID register and the lookup scan sequencer.
// Sequence: a lookup with stored IDs steps through SCAN over every stored ID, then WAIT
// and FINISH; an empty-table lookup, insert, clear and the unused code go to FINISH directly.
// Throughput: one item at a time; the next transfer is taken once the result has left
// the sequencer, so a lookup lasts longer the more IDs are stored, as one comparator scans them.
// Reset: synchronous, active low; clears the fill count, admin ID and handshake state.
`include "assert_macros.svh"

module card_id_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cidt_pkg::ID_W-1:0]   i_cfg_admin_id,
    // input items
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cidt_pkg::OP_W-1:0]   i_operation,
    input  logic [cidt_pkg::ID_W-1:0]   i_card_id,
    // results
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_found,
    output logic                        o_is_admin,
    output logic                        o_stored
);

    cidt_pkg::t_state                   r_state;
    cidt_pkg::t_state                   n_state;
    logic [cidt_pkg::ID_W-1:0]          r_admin_id;
    logic [cidt_pkg::CNT_W-1:0]         r_count;
    logic [cidt_pkg::IDX_W-1:0]         r_idx;
    logic [cidt_pkg::ID_W-1:0]          r_id;
    logic [cidt_pkg::ID_W-1:0]          r_rd_data;
    logic                               r_cmp_vld;
    logic                               r_hit;
    logic                               r_res_found;
    logic                               r_res_admin;
    logic                               r_res_stored;
    logic                               r_out_vld;
    logic                               r_found;
    logic                               r_is_admin;
    logic                               r_stored;
    logic [cidt_pkg::ID_W-1:0]          r_mem [cidt_pkg::CAPACITY];

    logic                               in_xfer;
    logic                               out_xfer;
    logic                               out_load;
    logic                               scan_last;
    logic                               not_full;
    logic                               admin_match;
    cidt_pkg::t_op                      op;

    assign op          = cidt_pkg::t_op'(i_operation);
    assign in_xfer     = i_valid && !o_stall;
    assign out_xfer    = r_out_vld && !i_stall;
    assign not_full    = (r_count < cidt_pkg::CAPACITY[cidt_pkg::CNT_W-1:0]);
    assign admin_match = (i_card_id == r_admin_id);
    assign scan_last   = ((cidt_pkg::CNT_W'(r_idx) + cidt_pkg::CNT_W'(1)) == r_count);

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_found     = r_found;
    assign o_is_admin  = r_is_admin;
    assign o_stored    = r_stored;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cidt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (op == cidt_pkg::OP_LOOKUP && r_count != '0) begin
                        n_state = cidt_pkg::ST_SCAN;
                    end else begin
                        n_state = cidt_pkg::ST_FINISH;
                    end
                end
            end
            cidt_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = cidt_pkg::ST_WAIT;
                end
            end
            cidt_pkg::ST_WAIT: begin
                n_state = cidt_pkg::ST_FINISH;
            end
            cidt_pkg::ST_FINISH: begin
                if (!r_out_vld || !i_stall) begin
                    n_state = cidt_pkg::ST_IDLE;
                end
            end
            default: n_state = cidt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall  = 1'b1;
        out_load = 1'b0;
        unique case (r_state)
            cidt_pkg::ST_IDLE:   o_stall = 1'b0;
            cidt_pkg::ST_SCAN:   o_stall = 1'b1;
            cidt_pkg::ST_WAIT:   o_stall = 1'b1;
            cidt_pkg::ST_FINISH: out_load = !r_out_vld || !i_stall;
            default:             o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cidt_pkg::ST_IDLE;
            r_admin_id <= '0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == cidt_pkg::ST_SCAN);
            if (i_cfg_valid && o_cfg_ready) begin
                r_admin_id <= i_cfg_admin_id;
            end
            if (in_xfer) begin
                if (op == cidt_pkg::OP_INSERT && not_full) begin
                    r_count <= r_count + cidt_pkg::CNT_W'(1);
                end else if (op == cidt_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_xfer) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ID store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_xfer && op == cidt_pkg::OP_INSERT && not_full) begin
            r_mem[r_count[cidt_pkg::IDX_W-1:0]] <= i_card_id;
        end
        r_rd_data <= r_mem[r_idx];
    end

    // scan datapath and result registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_id         <= i_card_id;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_res_admin  <= (op == cidt_pkg::OP_LOOKUP) && admin_match;
            r_res_found  <= (op == cidt_pkg::OP_LOOKUP) && admin_match;
            r_res_stored <= (op == cidt_pkg::OP_INSERT) && not_full;
        end else begin
            if (r_state == cidt_pkg::ST_SCAN) begin
                r_idx <= r_idx + cidt_pkg::IDX_W'(1);
            end
            if (r_cmp_vld && r_rd_data == r_id) begin
                r_hit <= 1'b1;
            end
        end
        if (out_load) begin
            r_found    <= r_res_found || r_hit;
            r_is_admin <= r_res_admin;
            r_stored   <= r_res_stored;
        end
    end

    `CIDT_ASSERT_ALWAYS(a_reset_idle,
        (!i_rst_n) |=> (r_state == cidt_pkg::ST_IDLE && !r_out_vld),
        "sequencer not idle after reset")
    `CIDT_ASSERT(a_count_range,
        r_count <= cidt_pkg::CAPACITY[cidt_pkg::CNT_W-1:0],
        "fill count above capacity")
    `CIDT_ASSERT(a_scan_in_range,
        (r_state == cidt_pkg::ST_SCAN) |-> (cidt_pkg::CNT_W'(r_idx) < r_count),
        "scan index past fill count")
    `CIDT_ASSERT(a_insert_count,
        (in_xfer && op == cidt_pkg::OP_INSERT && not_full)
            |=> (r_count == $past(r_count) + cidt_pkg::CNT_W'(1)),
        "insert did not advance fill count")
    `CIDT_ASSERT(a_result_source,
        (!r_out_vld ##1 r_out_vld) |-> ($past(r_state) == cidt_pkg::ST_FINISH),
        "result loaded outside finish")

endmodule
